FILE: design/cnhp_pkg.sv
// ----------------------------------------------------------------------------
// cnhp_pkg: shared types, constants and helpers of the cpio newc parser
// Holds the result and queue entry types, the parser phases, the result and
// error codes, and the small character tables used by the front end.
// ----------------------------------------------------------------------------
package cnhp_pkg;

  localparam int unsigned HEADER_LEN     = 110;
  localparam int unsigned MAGIC_LEN      = 6;
  localparam int unsigned HEX_DIGITS     = 8;
  localparam int unsigned TIME_OFS       = 46;
  localparam int unsigned SIZE_OFS       = 54;
  localparam int unsigned NSIZE_OFS      = 94;
  localparam int unsigned TRAILER_LEN    = 10;
  localparam int unsigned HEX_LOWER_BIAS = 87;
  localparam int unsigned HEX_UPPER_BIAS = 55;
  localparam int unsigned HEX_DIGIT_BIAS = 48;

  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_NAME   = 3'd1,
    PH_DATA   = 3'd2,
    PH_PAD    = 3'd3,
    PH_DONE   = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    KIND_NAME   = 3'd0,
    KIND_HEADER = 3'd1,
    KIND_DATA   = 3'd2,
    KIND_END    = 3'd3,
    KIND_ERROR  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_BAD_MAGIC = 2'd1,
    ERR_NAME_CUT  = 2'd2
  } error_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  byte_value;
    logic [31:0] entry_size;
    logic [31:0] mod_time;
    logic [31:0] name_length;
    error_e      error_code;
    logic        last_of_entry;
  } result_t;

  // One queue entry carries every result caused by one archive byte.
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  function automatic result_t make_result(kind_e kind, logic [7:0] value,
                                          error_e err, logic last);
    result_t r;
    r.kind          = kind;
    r.byte_value    = value;
    r.entry_size    = '0;
    r.mod_time      = '0;
    r.name_length   = '0;
    r.error_code    = err;
    r.last_of_entry = last;
    return r;
  endfunction

  function automatic logic [7:0] magic_char(logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h30;
      3'd1:    c = 8'h37;
      3'd2:    c = 8'h30;
      3'd3:    c = 8'h37;
      3'd4:    c = 8'h30;
      3'd5:    c = 8'h31;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] trailer_char(logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h54;
      4'd1:    c = 8'h52;
      4'd2:    c = 8'h41;
      4'd3:    c = 8'h49;
      4'd4:    c = 8'h4C;
      4'd5:    c = 8'h45;
      4'd6:    c = 8'h52;
      4'd7:    c = 8'h21;
      4'd8:    c = 8'h21;
      4'd9:    c = 8'h21;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Hex digit accumulation without validation; out-of-range bytes wrap.
  function automatic logic [31:0] hex_step(logic [31:0] acc, logic [7:0] c);
    logic [31:0] d;
    if (c > CHAR_UPPER_F) begin
      d = 32'(c) - 32'(HEX_LOWER_BIAS);
    end else if (c > CHAR_NINE) begin
      d = 32'(c) - 32'(HEX_UPPER_BIAS);
    end else begin
      d = 32'(c) - 32'(HEX_DIGIT_BIAS);
    end
    return {acc[27:0], 4'h0} + d;
  endfunction

endpackage

FILE: design/cpio_newc_header_parser_core.sv
// ----------------------------------------------------------------------------
// cpio_newc_header_parser_core: streaming cpio newc archive parser
// Takes one archive byte per transaction and gives name bytes, entry
// headers, data bytes, end of archive and error results.
// ----------------------------------------------------------------------------
// The block accepts one archive byte per clock cycle. A byte is parsed in the
// cycle it is accepted and its results enter a four-entry queue; the output
// register presents one result per cycle while out_stall_i is low, and the
// first result of a byte passes through the queue and then the output
// register before it is presented. Most bytes cause one result or none; the
// byte that completes the name area can add an entry header or end of archive
// result to a name byte, and a leading dot released together with the byte
// after it gives two name bytes. Such a pair is presented as two results.
// Input is stalled only while the queue is full, so the sustained rate is one
// byte per cycle as long as the output keeps up with the results.
module cpio_newc_header_parser_core
  import cnhp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  archive_byte_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  byte_value_o,
  output logic [31:0] entry_size_o,
  output logic [31:0] mod_time_o,
  output logic [31:0] name_length_o,
  output logic [1:0]  error_code_o,
  output logic        last_of_entry_o
);

  logic   q_full;
  logic   q_empty;
  logic   q_push;
  logic   q_pop;
  entry_t q_push_data;
  entry_t q_head;

  assign in_stall_o = q_full;

  cnhp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .archive_byte_i (archive_byte_i),
    .end_of_input_i (end_of_input_i),
    .full_i         (q_full),
    .push_o         (q_push),
    .push_data_o    (q_push_data)
  );

  cnhp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  cnhp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (q_head),
    .empty_i         (q_empty),
    .pop_o           (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .byte_value_o    (byte_value_o),
    .entry_size_o    (entry_size_o),
    .mod_time_o      (mod_time_o),
    .name_length_o   (name_length_o),
    .error_code_o    (error_code_o),
    .last_of_entry_o (last_of_entry_o)
  );

endmodule

FILE: design/cnhp_queue.sv
// ----------------------------------------------------------------------------
// cnhp_queue: short queue between the parser front end and the output stage
// A four-entry register queue; each entry holds the results of one byte.
// ----------------------------------------------------------------------------
module cnhp_queue
  import cnhp_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output entry_t head_o
);

  entry_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("queue written while full");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("queue read while empty");

endmodule

FILE: design/cnhp_front.sv
// ----------------------------------------------------------------------------
// cnhp_front: archive byte intake and parsing
// Tracks the header, name, data and padding phases, decodes the hex fields,
// strips a leading "./", watches for the trailer name and queues the results
// that each byte causes.
// ----------------------------------------------------------------------------
module cnhp_front
  import cnhp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] archive_byte_i,
  input  logic       end_of_input_i,
  input  logic       full_i,
  output logic       push_o,
  output entry_t     push_data_o
);

  phase_e      phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] size_q, size_d;
  logic [31:0] time_q, time_d;
  logic [31:0] nsize_q, nsize_d;
  logic [31:0] name_last_q, name_last_d;
  logic [31:0] emitted_q, emitted_d;
  logic        magic_good_q, magic_good_d;
  logic        name_ended_q, name_ended_d;
  logic        held_dot_q, held_dot_d;
  logic        trailer_q, trailer_d;

  logic        accept;
  logic        hdr_last;
  logic        name_last;
  logic        is_trailer;
  logic        data_last;
  logic        cnt_le_one;
  logic [1:0]  pad;
  logic        restart;
  logic        emit_dot;
  logic        try_byte;
  logic        emit_byte;
  logic [1:0]  n_res;
  result_t     r0, r1, fin;
  logic [1:0]  name_pad;
  logic [31:0] em_idx;

  assign accept     = in_valid_i && !full_i;
  assign hdr_last   = (pos_q >= 32'(HEADER_LEN - 1));
  assign name_last  = (pos_q == name_last_q);
  assign cnt_le_one = (pos_q <= 32'd1);
  assign data_last  = cnt_le_one;
  assign pad        = 2'(2'd0 - size_q[1:0]);

  // Phase sequencing.
  always_comb begin
    phase_d = phase_q;
    if (accept && phase_q != PH_DONE) begin
      if (end_of_input_i) begin
        phase_d = PH_DONE;
      end else begin
        case (phase_q)
          PH_HEADER: begin
            if (hdr_last) begin
              phase_d = magic_good_d ? PH_NAME : PH_DONE;
            end
          end
          PH_NAME: begin
            if (name_last) begin
              if (is_trailer) begin
                phase_d = PH_DONE;
              end else begin
                phase_d = (size_q != '0) ? PH_DATA : PH_HEADER;
              end
            end
          end
          PH_DATA: begin
            if (data_last) begin
              phase_d = (pad != '0) ? PH_PAD : PH_HEADER;
            end
          end
          PH_PAD: begin
            if (cnt_le_one) begin
              phase_d = PH_HEADER;
            end
          end
          default: phase_d = PH_DONE;
        endcase
      end
    end
  end

  // Datapath and result generation.
  always_comb begin
    pos_d        = pos_q;
    size_d       = size_q;
    time_d       = time_q;
    nsize_d      = nsize_q;
    name_last_d  = name_last_q;
    emitted_d    = emitted_q;
    magic_good_d = magic_good_q;
    name_ended_d = name_ended_q;
    held_dot_d   = held_dot_q;
    trailer_d    = trailer_q;
    restart      = 1'b0;
    is_trailer   = 1'b0;
    emit_dot     = 1'b0;
    try_byte     = 1'b0;
    emit_byte    = 1'b0;
    n_res        = '0;
    r0           = make_result(KIND_NAME, '0, ERR_NONE, 1'b0);
    r1           = r0;
    fin          = r0;
    name_pad     = 2'(2'd0 - 2'(nsize_q[1:0] + 2'd2));
    em_idx       = emitted_q;

    if (accept && phase_q != PH_DONE) begin
      if (end_of_input_i) begin
        r0 = (phase_q == PH_NAME) ? make_result(KIND_ERROR, '0, ERR_NAME_CUT, 1'b0)
                                  : make_result(KIND_END, '0, ERR_NONE, 1'b0);
        n_res      = 2'd1;
        held_dot_d = 1'b0;
      end else begin
        case (phase_q)
          PH_HEADER: begin
            if (pos_q < 32'(MAGIC_LEN) && magic_char(pos_q[2:0]) != archive_byte_i) begin
              magic_good_d = 1'b0;
            end
            if (pos_q >= 32'(TIME_OFS) && pos_q < 32'(TIME_OFS + HEX_DIGITS)) begin
              time_d = hex_step(time_q, archive_byte_i);
            end
            if (pos_q >= 32'(SIZE_OFS) && pos_q < 32'(SIZE_OFS + HEX_DIGITS)) begin
              size_d = hex_step(size_q, archive_byte_i);
            end
            if (pos_q >= 32'(NSIZE_OFS) && pos_q < 32'(NSIZE_OFS + HEX_DIGITS)) begin
              nsize_d = hex_step(nsize_q, archive_byte_i);
            end
            pos_d = pos_q + 32'd1;
            if (hdr_last) begin
              if (!magic_good_d) begin
                r0    = make_result(KIND_ERROR, '0, ERR_BAD_MAGIC, 1'b0);
                n_res = 2'd1;
              end else begin
                pos_d        = '0;
                name_ended_d = 1'b0;
                held_dot_d   = 1'b0;
                trailer_d    = 1'b1;
                emitted_d    = '0;
                // Index of the final byte of the padded name area.
                name_last_d  = nsize_q + 32'(name_pad) - 32'd1;
              end
            end
          end
          PH_NAME: begin
            if (pos_q == '0 && nsize_q > 32'd3 && archive_byte_i == CHAR_DOT) begin
              held_dot_d = 1'b1;
            end else if (pos_q == 32'd1 && held_dot_q) begin
              held_dot_d = 1'b0;
              if (archive_byte_i != CHAR_SLASH) begin
                emit_dot = 1'b1;
                try_byte = 1'b1;
              end
            end else begin
              try_byte = 1'b1;
            end
            if (try_byte && !name_ended_q && pos_q < nsize_q) begin
              if (archive_byte_i == CHAR_NUL) begin
                name_ended_d = 1'b1;
              end else begin
                emit_byte = 1'b1;
              end
            end

            if (emit_dot) begin
              if (em_idx >= 32'(TRAILER_LEN) || trailer_char(em_idx[3:0]) != CHAR_DOT) begin
                trailer_d = 1'b0;
              end
              em_idx = em_idx + 32'd1;
              r0     = make_result(KIND_NAME, CHAR_DOT, ERR_NONE, 1'b0);
              n_res  = 2'd1;
            end
            if (emit_byte) begin
              if (em_idx >= 32'(TRAILER_LEN) ||
                  trailer_char(em_idx[3:0]) != archive_byte_i) begin
                trailer_d = 1'b0;
              end
              em_idx = em_idx + 32'd1;
              if (n_res == 2'd0) begin
                r0 = make_result(KIND_NAME, archive_byte_i, ERR_NONE, 1'b0);
              end else begin
                r1 = make_result(KIND_NAME, archive_byte_i, ERR_NONE, 1'b0);
              end
              n_res = n_res + 2'd1;
            end
            emitted_d = em_idx;
            pos_d     = pos_q + 32'd1;

            if (name_last) begin
              is_trailer = trailer_d && (em_idx == 32'(TRAILER_LEN));
              if (is_trailer) begin
                fin = make_result(KIND_END, '0, ERR_NONE, 1'b0);
              end else begin
                fin             = make_result(KIND_HEADER, '0, ERR_NONE, 1'b0);
                fin.entry_size  = size_q;
                fin.mod_time    = time_q;
                fin.name_length = em_idx;
                if (size_q != '0) begin
                  pos_d = size_q;
                end else begin
                  restart = 1'b1;
                end
              end
              if (n_res == 2'd0) begin
                r0 = fin;
              end else begin
                r1 = fin;
              end
              n_res = n_res + 2'd1;
            end
          end
          PH_DATA: begin
            r0    = make_result(KIND_DATA, archive_byte_i, ERR_NONE, data_last);
            n_res = 2'd1;
            if (data_last) begin
              if (pad != '0) begin
                pos_d = 32'(pad);
              end else begin
                restart = 1'b1;
              end
            end else begin
              pos_d = pos_q - 32'd1;
            end
          end
          PH_PAD: begin
            if (cnt_le_one) begin
              restart = 1'b1;
            end else begin
              pos_d = pos_q - 32'd1;
            end
          end
          default: begin
            n_res = '0;
          end
        endcase
      end

      if (restart) begin
        pos_d        = '0;
        magic_good_d = 1'b1;
        size_d       = '0;
        time_d       = '0;
        nsize_d      = '0;
      end
    end
  end

  assign push_o           = (n_res != 2'd0);
  assign push_data_o.two  = (n_res == 2'd2);
  assign push_data_o.r0   = r0;
  assign push_data_o.r1   = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HEADER;
      pos_q        <= '0;
      size_q       <= '0;
      time_q       <= '0;
      nsize_q      <= '0;
      name_last_q  <= '0;
      emitted_q    <= '0;
      magic_good_q <= 1'b1;
      name_ended_q <= 1'b0;
      held_dot_q   <= 1'b0;
      trailer_q    <= 1'b1;
    end else begin
      phase_q      <= phase_d;
      pos_q        <= pos_d;
      size_q       <= size_d;
      time_q       <= time_d;
      nsize_q      <= nsize_d;
      name_last_q  <= name_last_d;
      emitted_q    <= emitted_d;
      magic_good_q <= magic_good_d;
      name_ended_q <= name_ended_d;
      held_dot_q   <= held_dot_d;
      trailer_q    <= trailer_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   phase_q == PH_DONE |=> phase_q == PH_DONE)
    else $error("parser left the finished phase");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   push_o && push_data_o.two |-> phase_q == PH_NAME)
    else $error("two results queued outside the name area");

endmodule

FILE: design/cnhp_back.sv
// ----------------------------------------------------------------------------
// cnhp_back: result output stage
// Takes queue entries and presents their results one per transaction from an
// output register.
// ----------------------------------------------------------------------------
module cnhp_back
  import cnhp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  entry_t      head_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  byte_value_o,
  output logic [31:0] entry_size_o,
  output logic [31:0] mod_time_o,
  output logic [31:0] name_length_o,
  output logic [1:0]  error_code_o,
  output logic        last_of_entry_o
);

  logic    out_valid_q, out_valid_d;
  logic    sel_q, sel_d;
  result_t out_q, out_d;
  logic    load;

  assign load = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    sel_d       = sel_q;
    out_d       = out_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = !empty_i;
      if (!empty_i) begin
        out_d = sel_q ? head_i.r1 : head_i.r0;
        // The second result of an entry goes out on the following transaction.
        if (sel_q || !head_i.two) begin
          pop_o = 1'b1;
          sel_d = 1'b0;
        end else begin
          sel_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sel_q       <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = out_q.kind;
  assign byte_value_o    = out_q.byte_value;
  assign entry_size_o    = out_q.entry_size;
  assign mod_time_o      = out_q.mod_time;
  assign name_length_o   = out_q.name_length;
  assign error_code_o    = out_q.error_code;
  assign last_of_entry_o = out_q.last_of_entry;

  assert property (@(posedge clk_i) disable iff (!rst_ni) sel_q |-> !empty_i)
    else $error("second result pending with no entry at the queue head");

endmodule

FILE: verif/cpio_newc_header_parser_core_tb.sv
// ----------------------------------------------------------------------------
// cpio_newc_header_parser_core_tb: self-checking bench for the cpio parser
// Feeds one archive of well-formed and awkward entries through the parser,
// predicts every result from a behavioural model of the format and compares
// each result field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module cpio_newc_header_parser_core_tb;
  import cnhp_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int ENTRY_BYTES  = 480;
  localparam int CALM_TAIL    = 100;
  localparam int HOLD_CYCLES  = 120;
  localparam int LIMIT_CYCLES = 500000;

  localparam logic [47:0] MAGIC_TXT   = "070701";
  localparam logic [79:0] TRAILER_TXT = "TRAILER!!!";

  typedef struct {
    logic [7:0] value;
    logic       eoi;
  } arc_item_t;

  typedef enum int {
    NAME_PLAIN, NAME_DOT_SLASH, NAME_DOT_OTHER, NAME_SHORT_DOT, NAME_EARLY_NUL,
    NAME_EMPTY, NAME_WRAP, NAME_NEAR_TRAILER, NAME_RAW, NAME_TRAILER,
    NAME_DOT_TRAILER
  } name_style_e;

  typedef enum int {
    STOP_IN_HEADER, STOP_IN_NAME, STOP_IN_DATA, STOP_IN_PAD, STOP_AT_TRAILER,
    STOP_BAD_MAGIC
  } stop_e;

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [7:0]  archive_byte_i  = 8'h00;
  logic        end_of_input_i  = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [2:0]  kind_o;
  logic [7:0]  byte_value_o;
  logic [31:0] entry_size_o;
  logic [31:0] mod_time_o;
  logic [31:0] name_length_o;
  logic [1:0]  error_code_o;
  logic        last_of_entry_o;

  arc_item_t   arc_stream[$];
  result_t     expected_results[$];
  logic [7:0]  name_buf[$];
  arc_item_t   next_item;
  result_t     oldest;

  int unsigned total_items;
  int unsigned n_accepted;
  int unsigned n_results;
  int unsigned n_errors;
  int unsigned n_entries;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned hold_left;
  bit          hold_done;
  bit          in_data_phase;
  stop_e       stop_kind;

  // Layout of the entry most recently appended to the stream.
  logic [31:0] entry_name_area;
  logic [31:0] entry_pad_len;

  // Parser state as predicted.
  phase_e      arc_phase;
  logic [31:0] pos;
  logic [31:0] size_acc;
  logic [31:0] time_acc;
  logic [31:0] nsize_acc;
  bit          magic_ok;
  bit          name_done;
  bit          dot_held;
  bit          trailer_ok;
  logic [31:0] name_cnt;

  cpio_newc_header_parser_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .archive_byte_i  (archive_byte_i),
    .end_of_input_i  (end_of_input_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .byte_value_o    (byte_value_o),
    .entry_size_o    (entry_size_o),
    .mod_time_o      (mod_time_o),
    .name_length_o   (name_length_o),
    .error_code_o    (error_code_o),
    .last_of_entry_o (last_of_entry_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    n_errors++;
    $display("MISMATCH at %0t: %s got %0h expected %0h", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] shift_in_digit(logic [31:0] acc, logic [7:0] c);
    logic [31:0] digit;
    if (c > CHAR_UPPER_F) begin
      digit = 32'(c) - HEX_LOWER_BIAS;
    end else if (c > CHAR_NINE) begin
      digit = 32'(c) - HEX_UPPER_BIAS;
    end else begin
      digit = 32'(c) - HEX_DIGIT_BIAS;
    end
    return (acc << 4) + digit;
  endfunction

  task automatic add_expected(input kind_e kind, input logic [7:0] value,
                              input logic [31:0] size, input logic [31:0] mtime,
                              input logic [31:0] nlen, input error_e err,
                              input logic last);
    result_t r;
    r.kind          = kind;
    r.byte_value    = value;
    r.entry_size    = size;
    r.mod_time      = mtime;
    r.name_length   = nlen;
    r.error_code    = err;
    r.last_of_entry = last;
    expected_results.push_back(r);
  endtask

  task automatic begin_header();
    arc_phase = PH_HEADER;
    pos       = '0;
    magic_ok  = 1'b1;
    size_acc  = '0;
    time_acc  = '0;
    nsize_acc = '0;
  endtask

  task automatic emit_name_byte(input logic [7:0] b);
    if (name_cnt >= TRAILER_LEN) begin
      trailer_ok = 1'b0;
    end else if (TRAILER_TXT[8 * (TRAILER_LEN - 1 - name_cnt) +: 8] != b) begin
      trailer_ok = 1'b0;
    end
    name_cnt++;
    add_expected(KIND_NAME, b, '0, '0, '0, ERR_NONE, 1'b0);
  endtask

  // A name byte counts only up to the first NUL and within the name size.
  task automatic take_name_byte(input logic [7:0] b, input logic [31:0] p);
    if (name_done || p >= nsize_acc) return;
    if (b == CHAR_NUL) name_done = 1'b1;
    else emit_name_byte(b);
  endtask

  task automatic parse_archive_byte(input logic [7:0] b, input logic eoi);
    logic [31:0] p;
    logic [31:0] area;
    logic [31:0] pad;
    p = pos;
    if (arc_phase == PH_DONE) return;
    if (eoi) begin
      if (arc_phase == PH_NAME) add_expected(KIND_ERROR, '0, '0, '0, '0, ERR_NAME_CUT, 1'b0);
      else add_expected(KIND_END, '0, '0, '0, '0, ERR_NONE, 1'b0);
      dot_held  = 1'b0;
      arc_phase = PH_DONE;
      return;
    end
    case (arc_phase)
      PH_HEADER: begin
        if (p < MAGIC_LEN) begin
          if (MAGIC_TXT[8 * (MAGIC_LEN - 1 - p) +: 8] != b) magic_ok = 1'b0;
        end
        if (p >= TIME_OFS && p < TIME_OFS + HEX_DIGITS) time_acc = shift_in_digit(time_acc, b);
        if (p >= SIZE_OFS && p < SIZE_OFS + HEX_DIGITS) size_acc = shift_in_digit(size_acc, b);
        if (p >= NSIZE_OFS && p < NSIZE_OFS + HEX_DIGITS) begin
          nsize_acc = shift_in_digit(nsize_acc, b);
        end
        p++;
        pos = p;
        if (p >= HEADER_LEN) begin
          if (!magic_ok) begin
            add_expected(KIND_ERROR, '0, '0, '0, '0, ERR_BAD_MAGIC, 1'b0);
            arc_phase = PH_DONE;
          end else begin
            arc_phase  = PH_NAME;
            pos        = '0;
            name_done  = 1'b0;
            dot_held   = 1'b0;
            trailer_ok = 1'b1;
            name_cnt   = '0;
          end
        end
      end
      PH_NAME: begin
        // The name area is padded so that header plus area is a multiple of 4.
        area = nsize_acc + ((32'd4 - ((nsize_acc + 32'd2) & 32'd3)) & 32'd3);
        if (p == 0 && nsize_acc > 3 && b == CHAR_DOT) begin
          dot_held = 1'b1;
        end else if (p == 1 && dot_held) begin
          dot_held = 1'b0;
          if (b != CHAR_SLASH) begin
            emit_name_byte(CHAR_DOT);
            take_name_byte(b, p);
          end
        end else begin
          take_name_byte(b, p);
        end
        p++;
        pos = p;
        if (p == area) begin
          if (trailer_ok && name_cnt == TRAILER_LEN) begin
            add_expected(KIND_END, '0, '0, '0, '0, ERR_NONE, 1'b0);
            arc_phase = PH_DONE;
          end else begin
            add_expected(KIND_HEADER, '0, size_acc, time_acc, name_cnt, ERR_NONE, 1'b0);
            if (size_acc != 0) begin
              arc_phase = PH_DATA;
              pos       = size_acc;
            end else begin
              begin_header();
            end
          end
        end
      end
      PH_DATA: begin
        add_expected(KIND_DATA, b, '0, '0, '0, ERR_NONE, p <= 1);
        if (p <= 1) begin
          pad = (32'd4 - (size_acc & 32'd3)) & 32'd3;
          if (pad != 0) begin
            arc_phase = PH_PAD;
            pos       = pad;
          end else begin
            begin_header();
          end
        end else begin
          pos = p - 1;
        end
      end
      PH_PAD: begin
        if (p <= 1) begin_header();
        else pos = p - 1;
      end
      default: arc_phase = PH_DONE;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Archive construction
  // ---------------------------------------------------------------------------

  task automatic put_byte(input logic [7:0] v);
    arc_item_t it;
    it.value = v;
    it.eoi   = 1'b0;
    arc_stream.push_back(it);
  endtask

  task automatic put_hex8(input logic [31:0] v, input bit garble);
    logic [3:0] d;
    logic [7:0] c;
    for (int i = HEX_DIGITS - 1; i >= 0; i--) begin
      d = v[4 * i +: 4];
      if (d < 10) c = 8'h30 + 8'(d);
      else if ($urandom_range(0, 1) == 1) c = 8'h61 + 8'(d) - 8'd10;
      else c = 8'h41 + 8'(d) - 8'd10;
      if (garble && $urandom_range(0, 2) == 0) c = 8'($urandom_range(0, 255));
      put_byte(c);
    end
  endtask

  task automatic put_trailer_text();
    for (int i = 0; i < TRAILER_LEN; i++) name_buf.push_back(TRAILER_TXT[8 * (9 - i) +: 8]);
  endtask

  task automatic put_random_chars(input int unsigned lo, input int unsigned hi);
    repeat ($urandom_range(lo, hi)) name_buf.push_back(8'($urandom_range(1, 255)));
  endtask

  task automatic make_name(input name_style_e style, output logic [31:0] nsize);
    int unsigned idx;
    name_buf.delete();
    case (style)
      NAME_PLAIN: begin
        put_random_chars(1, 10);
        name_buf.push_back(CHAR_NUL);
      end
      NAME_DOT_SLASH: begin
        name_buf.push_back(CHAR_DOT);
        name_buf.push_back(CHAR_SLASH);
        put_random_chars(1, 8);
        name_buf.push_back(CHAR_NUL);
      end
      NAME_DOT_OTHER: begin
        // The held dot is released together with whatever follows, NUL included.
        name_buf.push_back(CHAR_DOT);
        name_buf.push_back($urandom_range(0, 1) ? CHAR_DOT : 8'($urandom_range(0, 255)));
        if (name_buf[1] == CHAR_SLASH) name_buf[1] = CHAR_NUL;
        put_random_chars(1, 6);
        name_buf.push_back(CHAR_NUL);
      end
      NAME_SHORT_DOT: begin
        name_buf.push_back(CHAR_DOT);
        if ($urandom_range(0, 1) == 1) name_buf.push_back(CHAR_SLASH);
        name_buf.push_back(CHAR_NUL);
      end
      NAME_EARLY_NUL: begin
        put_random_chars(0, 4);
        name_buf.push_back(CHAR_NUL);
        put_random_chars(1, 5);
        name_buf.push_back(CHAR_NUL);
      end
      NAME_RAW: begin
        repeat ($urandom_range(1, 12)) name_buf.push_back(8'($urandom_range(0, 255)));
      end
      NAME_NEAR_TRAILER: begin
        put_trailer_text();
        case ($urandom_range(0, 2))
          0: repeat ($urandom_range(1, 9)) void'(name_buf.pop_back());
          1: name_buf.push_back(8'($urandom_range(1, 255)));
          default: begin
            idx = $urandom_range(0, TRAILER_LEN - 1);
            name_buf[idx] = name_buf[idx] ^ 8'($urandom_range(1, 255));
            if (name_buf[idx] == CHAR_NUL) name_buf[idx] = CHAR_DOT;
          end
        endcase
        name_buf.push_back(CHAR_NUL);
      end
      NAME_TRAILER: begin
        put_trailer_text();
        if ($urandom_range(0, 1) == 1) name_buf.push_back(CHAR_NUL);
      end
      NAME_DOT_TRAILER: begin
        name_buf.push_back(CHAR_DOT);
        name_buf.push_back(CHAR_SLASH);
        put_trailer_text();
        name_buf.push_back(CHAR_NUL);
      end
      NAME_WRAP: begin
        // A name size of all ones wraps the padded area round to two bytes.
        if ($urandom_range(0, 1) == 1) begin
          name_buf.push_back(CHAR_DOT);
          name_buf.push_back(CHAR_SLASH);
        end else begin
          put_random_chars(2, 2);
        end
      end
      default: ;
    endcase
    nsize = (style == NAME_WRAP) ? 32'hFFFF_FFFF : 32'(name_buf.size());
  endtask

  task automatic put_entry(input bit good_magic, input logic [31:0] mtime,
                           input logic [31:0] size, input logic [31:0] nsize,
                           input bit garble_time);
    int unsigned bad_at;
    logic [7:0]  c;
    bad_at          = $urandom_range(0, MAGIC_LEN - 1);
    entry_name_area = nsize + ((32'd4 - ((nsize + 32'd2) & 32'd3)) & 32'd3);
    entry_pad_len   = (32'd4 - (size & 32'd3)) & 32'd3;
    for (int p = 0; p < MAGIC_LEN; p++) begin
      c = MAGIC_TXT[8 * (MAGIC_LEN - 1 - p) +: 8];
      if (!good_magic && p == bad_at) c = c ^ 8'($urandom_range(1, 255));
      put_byte(c);
    end
    for (int p = MAGIC_LEN; p < TIME_OFS; p++) put_byte(8'($urandom_range(0, 255)));
    put_hex8(mtime, garble_time);
    put_hex8(size, 1'b0);
    for (int p = SIZE_OFS + HEX_DIGITS; p < NSIZE_OFS; p++) put_byte(8'($urandom_range(0, 255)));
    put_hex8(nsize, 1'b0);
    for (int p = NSIZE_OFS + HEX_DIGITS; p < HEADER_LEN; p++) begin
      put_byte(8'($urandom_range(0, 255)));
    end
    for (int unsigned p = 0; p < entry_name_area; p++) begin
      put_byte((p < name_buf.size()) ? name_buf[p] : 8'($urandom_range(0, 255)));
    end
    repeat (size + entry_pad_len) put_byte(8'($urandom_range(0, 255)));
    n_entries++;
  endtask

  // ---------------------------------------------------------------------------
  // Channels
  // ---------------------------------------------------------------------------

  function automatic bit quiet_now();
    return (arc_stream.size() < CALM_TAIL) || ((n_accepted / 97) % 4 == 1);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      archive_byte_i <= 8'h00;
      end_of_input_i <= 1'b0;
      gap_left       <= 0;
      n_accepted     <= 0;
      in_data_phase  <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        parse_archive_byte(archive_byte_i, end_of_input_i);
        n_accepted <= n_accepted + 1;
      end
      in_data_phase <= (arc_phase == PH_DATA);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          in_valid_i <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (arc_stream.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (!quiet_now() && hold_left == 0 && $urandom_range(0, 7) == 0) begin
          in_valid_i <= 1'b0;
          gap_left   <= $urandom_range(0, 9);
        end else begin
          next_item      = arc_stream.pop_front();
          in_valid_i     <= 1'b1;
          archive_byte_i <= next_item.value;
          end_of_input_i <= next_item.eoi;
        end
      end
    end
  end

  // One long output hold-off while data bytes stream in, so that the result
  // queue fills and the parser has to stall its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_accepted >= 100 && in_data_phase) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
      n_results   <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        n_results <= n_results + 1;
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing pending, kind", 32'(kind_o), '1);
        end else begin
          oldest = expected_results.pop_front();
          if (kind_o !== oldest.kind) begin
            report_mismatch("kind", 32'(kind_o), 32'(oldest.kind));
          end
          if (byte_value_o !== oldest.byte_value) begin
            report_mismatch("byte_value", 32'(byte_value_o), 32'(oldest.byte_value));
          end
          if (entry_size_o !== oldest.entry_size) begin
            report_mismatch("entry_size", entry_size_o, oldest.entry_size);
          end
          if (mod_time_o !== oldest.mod_time) begin
            report_mismatch("mod_time", mod_time_o, oldest.mod_time);
          end
          if (name_length_o !== oldest.name_length) begin
            report_mismatch("name_length", name_length_o, oldest.name_length);
          end
          if (error_code_o !== oldest.error_code) begin
            report_mismatch("error_code", 32'(error_code_o), 32'(oldest.error_code));
          end
          if (last_of_entry_o !== oldest.last_of_entry) begin
            report_mismatch("last_of_entry", 32'(last_of_entry_o),
                            32'(oldest.last_of_entry));
          end
        end
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
      end else if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_left - 1;
      end else if (!quiet_now() && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(0, 9);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    arc_item_t   tail_item;
    name_style_e style;
    logic [31:0] nsize;
    logic [31:0] size;
    logic [31:0] mtime;
    int unsigned whole;
    int unsigned keep;
    int unsigned r;

    begin_header();
    name_done  = 1'b0;
    dot_held   = 1'b0;
    trailer_ok = 1'b1;
    name_cnt   = '0;

    // The first entry carries enough data to fill the result queue during the
    // output hold-off, and the first two carry the extreme time values.
    while (arc_stream.size() < ENTRY_BYTES) begin
      r = $urandom_range(0, 11);
      style = (r > NAME_RAW) ? NAME_DOT_SLASH : name_style_e'(r);
      make_name(style, nsize);
      if (n_entries == 0) begin
        size = 32'($urandom_range(16, 24));
      end else begin
        size = ($urandom_range(0, 4) == 0) ? 32'd0 : 32'($urandom_range(1, 24));
      end
      if (n_entries == 0) mtime = 32'h0;
      else if (n_entries == 1) mtime = 32'hFFFF_FFFF;
      else mtime = $urandom;
      put_entry(1'b1, mtime, size, nsize, $urandom_range(0, 3) == 0);
    end

    // The archive ends only once per run, so the way it ends is drawn at random.
    stop_kind = stop_e'($urandom_range(0, STOP_BAD_MAGIC));
    if (stop_kind == STOP_AT_TRAILER) begin
      style = ($urandom_range(0, 1) == 1) ? NAME_TRAILER : NAME_DOT_TRAILER;
    end else begin
      style = NAME_PLAIN;
    end
    make_name(style, nsize);
    if (stop_kind == STOP_IN_PAD) size = 32'(4 * $urandom_range(0, 4) + $urandom_range(1, 3));
    else if (stop_kind == STOP_IN_DATA) size = 32'($urandom_range(1, 20));
    else size = 32'($urandom_range(0, 20));
    put_entry(stop_kind != STOP_BAD_MAGIC, $urandom, size, nsize, 1'b0);
    whole = HEADER_LEN + entry_name_area + size + entry_pad_len;
    case (stop_kind)
      STOP_IN_HEADER: keep = $urandom_range(0, HEADER_LEN - 1);
      STOP_IN_NAME:   keep = HEADER_LEN + $urandom_range(0, entry_name_area - 1);
      STOP_IN_DATA:   keep = HEADER_LEN + entry_name_area + $urandom_range(0, size - 1);
      STOP_IN_PAD: begin
        keep = HEADER_LEN + entry_name_area + size + $urandom_range(0, entry_pad_len - 1);
      end
      default:        keep = whole;
    endcase
    repeat (whole - keep) void'(arc_stream.pop_back());
    if (keep != whole) begin
      tail_item.value = 8'($urandom_range(0, 255));
      tail_item.eoi   = 1'b1;
      arc_stream.push_back(tail_item);
    end
    // Anything after the end of the archive is taken but must cause nothing.
    repeat (4) begin
      tail_item.value = 8'($urandom_range(0, 255));
      tail_item.eoi   = 1'($urandom_range(0, 1));
      arc_stream.push_back(tail_item);
    end
    tail_item.eoi = 1'b1;
    arc_stream.push_back(tail_item);
    total_items = arc_stream.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted != total_items) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    $display("Parsed %0d entries from %0d archive bytes, %0d results checked, ended by %s.",
             n_entries, total_items, n_results, stop_kind.name());
    $display("Output hold-off with a full result queue %s.",
             hold_done ? "was exercised" : "did not occur");
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
